// File: hw/rtl/trd_pkg.sv
package trd_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int RUN_W    = 8;
    localparam int DIM_W    = 16;
    localparam int TOTAL_W  = 32;
    localparam int PB_W     = 3;
    localparam int CFG_AW   = 2;
    localparam int POS_W    = 2;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // register indexes on the config port
    localparam logic [CFG_AW-1:0] CFG_PIXEL_BYTES  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [PB_W-1:0]  PIXEL_BYTES_RESET = 3'd3;
    localparam logic [PB_W-1:0]  PIXEL_BYTES_WIDE  = 3'd4;
    localparam logic [DIM_W-1:0] DIM_RESET         = 16'd1;

    // byte slots inside a pixel (B,G,R,A order on the wire)
    localparam logic [POS_W-1:0] POS_BLUE  = 2'd0;
    localparam logic [POS_W-1:0] POS_GREEN = 2'd1;
    localparam logic [POS_W-1:0] POS_RED   = 2'd2;
    localparam logic [POS_W-1:0] POS_ALPHA = 2'd3;

    localparam int HDR_REPEAT_BIT = 7;

    // one decoded pixel, classified, waiting for run accounting
    typedef struct packed {
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic               is_repeat;
        logic [COUNT_W-1:0] count;
        logic               more;
        logic               fresh;
    } pixel_token_t;

    typedef struct packed {
        logic done;
        logic fresh_taken;
    } back_status_t;

endpackage

// File: hw/rtl/trd_queue.sv
module trd_queue #(
    parameter int DEPTH = trd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  trd_pkg::pixel_token_t push_data,
    input  logic                  pop,
    output trd_pkg::pixel_token_t head,
    output logic                  empty,
    output logic                  full
);
    import trd_pkg::*;

    // DEPTH must be a power of two, at least 2
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pixel_token_t          slot_reg [DEPTH];
    logic [PW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

// File: hw/rtl/trd_front.sv
module trd_front #(
    parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic [trd_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         frame_start,
    input  logic [trd_pkg::PB_W-1:0]     pixel_bytes,
    input  logic                         total_zero,
    input  trd_pkg::back_status_t        back_status,
    output logic                         push,
    output trd_pkg::pixel_token_t        token
);
    import trd_pkg::*;

    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic               expect_hdr_reg, expect_hdr_next;
    logic               repeat_reg, repeat_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BYTE_W-1:0]  red_reg, red_next;
    logic [BYTE_W-1:0]  green_reg, green_next;
    logic [BYTE_W-1:0]  blue_reg, blue_next;
    logic               fresh_tag_reg, fresh_tag_next;
    logic [FW-1:0]      fresh_cnt_reg, fresh_cnt_next;

    logic               cur_exp, cur_rep, cur_fresh, pending, gate;
    logic [COUNT_W-1:0] cur_cnt;
    logic [POS_W-1:0]   cur_pos, last_pos;

    // frame_start clears decode state before the byte is looked at
    assign cur_exp   = frame_start | expect_hdr_reg;
    assign cur_rep   = frame_start ? 1'b0 : repeat_reg;
    assign cur_cnt   = frame_start ? '0 : count_reg;
    assign cur_pos   = frame_start ? POS_BLUE : pos_reg;
    assign cur_fresh = frame_start | fresh_tag_reg;
    assign last_pos  = (pixel_bytes == PIXEL_BYTES_WIDE) ? POS_ALPHA : POS_RED;

    // Until the back end has seen the new frame's first pixel its
    // done flag still belongs to the old frame; only a zero size counts.
    assign pending = fresh_tag_reg | (fresh_cnt_reg != '0);
    assign gate    = (frame_start || pending) ? total_zero : back_status.done;

    always_comb begin
        expect_hdr_next = expect_hdr_reg;
        repeat_next     = repeat_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        fresh_tag_next  = fresh_tag_reg;
        push            = 1'b0;
        if (accept) begin
            expect_hdr_next = cur_exp;
            repeat_next     = cur_rep;
            count_next      = cur_cnt;
            pos_next        = cur_pos;
            fresh_tag_next  = cur_fresh;
            if (!gate) begin
                if (cur_exp) begin
                    repeat_next     = data_byte[HDR_REPEAT_BIT];
                    count_next      = data_byte[COUNT_W-1:0];
                    expect_hdr_next = 1'b0;
                    pos_next        = POS_BLUE;
                end else begin
                    case (cur_pos)
                        POS_BLUE:  blue_next  = data_byte;
                        POS_GREEN: green_next = data_byte;
                        POS_RED:   red_next   = data_byte;
                        default:   ;
                    endcase
                    if (cur_pos < last_pos) begin
                        pos_next = cur_pos + POS_W'(1);
                    end else begin
                        pos_next       = POS_BLUE;
                        push           = 1'b1;
                        fresh_tag_next = 1'b0;
                        if (cur_rep || cur_cnt == '0) begin
                            expect_hdr_next = 1'b1;
                        end else begin
                            count_next = cur_cnt - COUNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        token.red       = red_next;
        token.green     = green_next;
        token.blue      = blue_next;
        token.is_repeat = cur_rep;
        token.count     = cur_cnt;
        token.more      = !cur_rep && (cur_cnt != '0);
        token.fresh     = cur_fresh;
    end

    always_comb begin
        fresh_cnt_next = fresh_cnt_reg;
        case ({push && token.fresh, back_status.fresh_taken})
            2'b10:   fresh_cnt_next = fresh_cnt_reg + FW'(1);
            2'b01:   fresh_cnt_next = fresh_cnt_reg - FW'(1);
            default: fresh_cnt_next = fresh_cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_hdr_reg <= 1'b1;
            repeat_reg     <= 1'b0;
            count_reg      <= '0;
            pos_reg        <= POS_BLUE;
            fresh_tag_reg  <= 1'b0;
            fresh_cnt_reg  <= '0;
        end else begin
            expect_hdr_reg <= expect_hdr_next;
            repeat_reg     <= repeat_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            fresh_tag_reg  <= fresh_tag_next;
            fresh_cnt_reg  <= fresh_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_cnt_reg <= FW'(QUEUE_DEPTH))
        else $error("more new-frame pixels in flight than queue slots");

endmodule

// File: hw/rtl/trd_back.sv
module trd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [trd_pkg::TOTAL_W-1:0]   total,
    input  trd_pkg::pixel_token_t         head,
    input  logic                          q_empty,
    output logic                          pop,
    output trd_pkg::back_status_t         back_status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [trd_pkg::BYTE_W-1:0]    m_red,
    output logic [trd_pkg::BYTE_W-1:0]    m_green,
    output logic [trd_pkg::BYTE_W-1:0]    m_blue,
    output logic [trd_pkg::RUN_W-1:0]     m_run_length,
    output logic                          m_last_run,
    output logic                          m_overrun
);
    import trd_pkg::*;

    logic [TOTAL_W-1:0] pixels_done_reg, pixels_done_next;
    logic               image_done_reg, image_done_next;
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_red_reg, m_green_reg, m_blue_reg;
    logic [RUN_W-1:0]   m_run_length_reg;
    logic               m_last_run_reg, m_overrun_reg;

    logic [TOTAL_W-1:0] pd_eff, left;
    logic               id_eff, done, left_narrow, clip;
    logic [RUN_W-1:0]   run_rep, run;
    logic               last, over;

    assign pop = !q_empty && (!m_valid_reg || m_ready);

    // a new frame's first pixel restarts the count
    assign pd_eff      = head.fresh ? '0 : pixels_done_reg;
    assign id_eff      = head.fresh ? 1'b0 : image_done_reg;
    assign done        = id_eff || (pd_eff >= total);
    assign left        = total - pd_eff;
    assign left_narrow = (left[TOTAL_W-1:RUN_W] == '0);
    assign run_rep     = RUN_W'(head.count) + RUN_W'(1);
    assign clip        = left_narrow && (left[RUN_W-1:0] < run_rep);

    always_comb begin
        if (head.is_repeat) begin
            run  = clip ? left[RUN_W-1:0] : run_rep;
            last = left_narrow && (left[RUN_W-1:0] <= run_rep);
            over = clip;
        end else begin
            run  = RUN_W'(1);
            last = (left == TOTAL_W'(1));
            over = last && head.more;
        end
    end

    always_comb begin
        pixels_done_next = pixels_done_reg;
        image_done_next  = image_done_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        if (pop) begin
            pixels_done_next = pd_eff;
            image_done_next  = id_eff;
            if (!done) begin
                pixels_done_next = pd_eff + TOTAL_W'(run);
                image_done_next  = last;
                m_valid_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixels_done_reg <= '0;
            image_done_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            pixels_done_reg <= pixels_done_next;
            image_done_reg  <= image_done_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && !done) begin
            m_red_reg        <= head.red;
            m_green_reg      <= head.green;
            m_blue_reg       <= head.blue;
            m_run_length_reg <= run;
            m_last_run_reg   <= last;
            m_overrun_reg    <= over;
        end
    end

    assign back_status.done        = image_done_reg || (pixels_done_reg >= total);
    assign back_status.fresh_taken = pop && head.fresh;

    assign m_valid      = m_valid_reg;
    assign m_red        = m_red_reg;
    assign m_green      = m_green_reg;
    assign m_blue       = m_blue_reg;
    assign m_run_length = m_run_length_reg;
    assign m_last_run   = m_last_run_reg;
    assign m_overrun    = m_overrun_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_overrun_reg |-> m_last_run_reg)
        else $error("clipped run not marked as last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_run_length_reg != '0)
        else $error("zero-length run emitted");

endmodule

// File: hw/rtl/tga_rle_pixel_decoder.sv
// Channel  | Ports                                  | Carries
// ---------+----------------------------------------+-------------------------------
// input    | s_valid s_ready s_data_byte            | one coded byte per transaction
//          | s_frame_start                          |
// output   | m_valid m_ready m_red m_green m_blue   | one RGB run per transaction
//          | m_run_length m_last_run m_overrun      |
// config   | cfg_wr_en cfg_addr cfg_wr_data         | register write, no wait
//
// One byte is taken every clock while s_ready is high; the front end classifies
// it in that cycle. With the output side free, the pixel that a byte completes
// is written to a queue slot and then to the output register, which raises
// m_valid.
// s_ready drops only while the pixel queue is full: the output register holds a
// stalled result and QUEUE_DEPTH more pixels wait behind it. While it is low
// every byte waits, header and partial-pixel bytes included.
// Reset is synchronous and active low; no clearing pass is needed.
module tga_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // coded byte stream
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [trd_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                          s_frame_start,
    // decoded runs
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [trd_pkg::BYTE_W-1:0]    m_red,
    output logic [trd_pkg::BYTE_W-1:0]    m_green,
    output logic [trd_pkg::BYTE_W-1:0]    m_blue,
    output logic [trd_pkg::RUN_W-1:0]     m_run_length,
    output logic                          m_last_run,
    output logic                          m_overrun,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [trd_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [trd_pkg::DIM_W-1:0]     cfg_wr_data
);
    import trd_pkg::*;

    // configuration registers; the pixel total is formed at write time so the
    // run accounting never sits behind a multiplier
    logic [PB_W-1:0]    pixel_bytes_reg, pixel_bytes_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic               s_accept;
    logic               push, pop, q_empty, q_full;
    pixel_token_t       push_token, head_token;
    back_status_t       back_status;

    always_comb begin
        pixel_bytes_next = pixel_bytes_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        total_next       = total_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PIXEL_BYTES: begin
                    pixel_bytes_next = cfg_wr_data[PB_W-1:0];
                end
                CFG_IMAGE_WIDTH: begin
                    width_next = cfg_wr_data;
                    total_next = TOTAL_W'(cfg_wr_data) * TOTAL_W'(height_reg);
                end
                CFG_IMAGE_HEIGHT: begin
                    height_next = cfg_wr_data;
                    total_next  = TOTAL_W'(width_reg) * TOTAL_W'(cfg_wr_data);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_bytes_reg <= PIXEL_BYTES_RESET;
            width_reg       <= DIM_RESET;
            height_reg      <= DIM_RESET;
            total_reg       <= TOTAL_W'(DIM_RESET);
        end else begin
            pixel_bytes_reg <= pixel_bytes_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            total_reg       <= total_next;
        end
    end

    // the queue is the only back-pressure source on the input
    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    // front end: header parsing, byte gathering, pixel classification
    trd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .data_byte   (s_data_byte),
        .frame_start (s_frame_start),
        .pixel_bytes (pixel_bytes_reg),
        .total_zero  (total_reg == '0),
        .back_status (back_status),
        .push        (push),
        .token       (push_token)
    );

    // decouples byte intake from output stalls
    trd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_token),
        .pop       (pop),
        .head      (head_token),
        .empty     (q_empty),
        .full      (q_full)
    );

    // back end: pixel counting, clipping at image end, output register
    trd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .total        (total_reg),
        .head         (head_token),
        .q_empty      (q_empty),
        .pop          (pop),
        .back_status  (back_status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_run_length (m_run_length),
        .m_last_run   (m_last_run),
        .m_overrun    (m_overrun)
    );

endmodule

// File: verif/tga_rle_pixel_decoder_test.sv
module tga_rle_pixel_decoder_test;

    import trd_pkg::*;

    localparam int ITEMS_TARGET     = 1650;   // decoded (not ignored) bytes to push through
    localparam int TAIL_ITEMS       = 250;    // last stretch runs with both sides streaming
    localparam int SETTLE_CYCLES    = 4;      // front end + queue + output register, with slack
    localparam int DRAIN_CYCLES     = 32;
    localparam int LONG_HOLD_CYCLES = 64;     // well past QUEUE_DEPTH results
    localparam int MAX_PRINTED      = 40;
    localparam int TIMEOUT_UNITS    = 8 * 400000;

    // one decoded RGB run as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [RUN_W-1:0]  run_length;
        logic              last_run;
        logic              overrun;
    } run_t;

    // directed script: a byte transaction or a register write
    typedef enum logic {ROW_BYTE, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [CFG_AW-1:0] idx;
        logic [DIM_W-1:0]  value;   // register value, or the coded byte in the low bits
        logic              fs;
        logic              typed;   // run below is written out by hand
        run_t              want;
    } script_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_data_byte;
    logic                s_frame_start;
    logic                m_valid;
    logic                m_ready;
    logic [BYTE_W-1:0]   m_red;
    logic [BYTE_W-1:0]   m_green;
    logic [BYTE_W-1:0]   m_blue;
    logic [RUN_W-1:0]    m_run_length;
    logic                m_last_run;
    logic                m_overrun;
    logic                cfg_wr_en;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [DIM_W-1:0]    cfg_wr_data;

    // decoder copy: registers
    logic [PB_W-1:0]     pb_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    // decoder copy: packet / pixel tracking
    bit                  hdr_due;
    bit                  pkt_repeat;
    logic [7:0]          pkt_count;
    logic [POS_W-1:0]    byte_pos;
    logic [TOTAL_W-1:0]  held;
    logic [TOTAL_W-1:0]  pix_done;
    bit                  img_done;

    run_t                runs_due[$];
    script_row_t         script[$];

    int                  bytes_used;
    int                  runs_checked;
    int                  image_ends;
    int                  clipped_runs;
    int                  mismatches;
    int                  tx_idle_odds;     // percent chance of a gap before a transaction
    int                  rx_idle_odds;     // percent chance per cycle of a stall burst
    int unsigned         rx_stall_left = 0;
    bit                  rx_long_hold_req = 1'b0;

    tga_rle_pixel_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_run_length  (m_run_length),
        .m_last_run    (m_last_run),
        .m_overrun     (m_overrun),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // anything other than the wide setting means 3-byte pixels
    function automatic int px_bytes();
        return (pb_reg == PIXEL_BYTES_WIDE) ? 4 : 3;
    endfunction

    function automatic void clear_decode();
        hdr_due    = 1'b1;
        pkt_repeat = 1'b0;
        pkt_count  = '0;
        byte_pos   = POS_BLUE;
        held       = '0;
        pix_done   = '0;
        img_done   = 1'b0;
    endfunction

    // Advances the decoder copy by one coded byte; returns 1 when a run comes out.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic fs,
                                       output run_t r);
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] left;
        logic [TOTAL_W-1:0] run;
        int                 need;
        r     = '0;
        total = TOTAL_W'(width_reg) * TOTAL_W'(height_reg);
        need  = px_bytes();
        if (fs)
            clear_decode();
        // finished image (also zero size or shrunk size): byte is dropped
        if (img_done || pix_done >= total)
            return 1'b0;
        bytes_used++;
        if (hdr_due) begin
            pkt_repeat = b[HDR_REPEAT_BIT];
            pkt_count  = {1'b0, b[COUNT_W-1:0]};
            hdr_due    = 1'b0;
            byte_pos   = POS_BLUE;
            held       = '0;
            return 1'b0;
        end
        held[BYTE_W*byte_pos +: BYTE_W] = b;
        if (int'(byte_pos) + 1 < need) begin
            byte_pos++;
            return 1'b0;
        end
        byte_pos = POS_BLUE;
        left     = total - pix_done;
        if (pkt_repeat) begin
            run = pkt_count + 1;
            if (run > left) begin
                run       = left;    // clipped at image end
                r.overrun = 1'b1;
            end
            hdr_due = 1'b1;
        end else begin
            run = 1;
            if (pkt_count == 0)
                hdr_due = 1'b1;
            else
                pkt_count--;
        end
        pix_done  += run;
        r.last_run = (pix_done >= total);
        if (r.last_run) begin
            img_done = 1'b1;
            // raw packet with pixels still owed when the image filled up
            if (!pkt_repeat && !hdr_due)
                r.overrun = 1'b1;
        end
        r.red        = held[23:16];
        r.green      = held[15:8];
        r.blue       = held[7:0];
        r.run_length = run[RUN_W-1:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed script builders
    // ------------------------------------------------------------------

    function automatic void script_reg(input logic [CFG_AW-1:0] idx,
                                       input logic [DIM_W-1:0] value);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = value;
        script.push_back(row);
    endfunction

    function automatic void script_byte(input logic [BYTE_W-1:0] b, input logic fs);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_BYTE;
        row.value = DIM_W'(b);
        row.fs    = fs;
        script.push_back(row);
    endfunction

    function automatic void script_run(input logic [BYTE_W-1:0] b, input logic fs,
                                       input logic [BYTE_W-1:0] red,
                                       input logic [BYTE_W-1:0] green,
                                       input logic [BYTE_W-1:0] blue,
                                       input logic [RUN_W-1:0] len,
                                       input logic last, input logic over);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_BYTE;
        row.value = DIM_W'(b);
        row.fs    = fs;
        row.typed = 1'b1;
        row.want  = '{red: red, green: green, blue: blue, run_length: len,
                      last_run: last, overrun: over};
        script.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Called at a clock edge; returns at the edge where the transaction is taken.
    // s_valid stays high on return so back-to-back bytes need no extra edge.
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic fs,
                             input bit typed = 1'b0, input run_t want = '0);
        run_t guess;
        bit   has_run;
        if (tx_idle_odds != 0 && $urandom_range(1, 100) <= tx_idle_odds) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= data;
        s_frame_start <= fs;
        do
            @(posedge aclk);
        while (!s_ready);
        has_run = decode_byte(data, fs, guess);
        if (typed)
            runs_due.push_back(want);
        else if (has_run)
            runs_due.push_back(guess);
    endtask

    task automatic send_pixel(input int nbytes);
        repeat (nbytes) send_byte(BYTE_W'($urandom), 1'b0);
    endtask

    // stop offering, wait for every expected run, then let the pipe empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (runs_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [DIM_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (idx)
            CFG_PIXEL_BYTES:  pb_reg     = value[PB_W-1:0];
            CFG_IMAGE_WIDTH:  width_reg  = value;
            CFG_IMAGE_HEIGHT: height_reg = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready       <= 1'b0;
            rx_stall_left <= 0;
        end else if (rx_stall_left != 0) begin
            m_ready       <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_long_hold_req) begin
            // long hold: queue fills and s_ready has to drop
            rx_long_hold_req = 1'b0;
            m_ready       <= 1'b0;
            rx_stall_left <= LONG_HOLD_CYCLES - 1;
        end else if (rx_idle_odds != 0 && $urandom_range(1, 100) <= rx_idle_odds) begin
            m_ready       <= 1'b0;
            rx_stall_left <= $urandom_range(0, 8);
        end else begin
            m_ready       <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("run %0d %s: got %0d, expected %0d",
                                    runs_checked, name, got, want));
    endtask

    always @(posedge aclk) begin : run_check
        run_t want;
        if (aresetn && m_valid && m_ready) begin
            if (runs_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected run rgb=%02h%02h%02h len=%0d",
                                        m_red, m_green, m_blue, m_run_length));
            end else begin
                want = runs_due.pop_front();
                check_field("red",        m_red,        want.red);
                check_field("green",      m_green,      want.green);
                check_field("blue",       m_blue,       want.blue);
                check_field("run_length", m_run_length, want.run_length);
                check_field("last_run",   m_last_run,   want.last_run);
                check_field("overrun",    m_overrun,    want.overrun);
                image_ends   += want.last_run;
                clipped_runs += want.overrun;
                runs_checked++;
            end
        end
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned      shape;
        int unsigned      pb_pick;
        int unsigned      cnt;
        int unsigned      made;
        int unsigned      cap;
        int unsigned      p;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        bit               rep;
        bit               restart;
        bit               tail;
        int               phases;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_frame_start = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wr_data   = '0;
        pb_reg        = PIXEL_BYTES_RESET;
        width_reg     = DIM_RESET;
        height_reg    = DIM_RESET;
        clear_decode();
        tx_idle_odds  = 20;
        rx_idle_odds  = 20;
        phases        = 0;

        // Reset config: 3-byte pixels, 1x1 image.
        // 128-pixel repeat packet into a 1-pixel image: clipped to 1, overrun set.
        script_byte(8'hFF, 1'b1);
        script_byte(8'h00, 1'b0);
        script_byte(8'hFF, 1'b0);
        script_run (8'h5A, 1'b0, 8'h5A, 8'hFF, 8'h00, 8'd1, 1'b1, 1'b1);
        script_byte(8'h12, 1'b0);                 // image complete: dropped
        // largest image, 4-byte pixels, full-length repeat run
        script_reg (CFG_PIXEL_BYTES,  DIM_W'(PIXEL_BYTES_WIDE));
        script_reg (CFG_IMAGE_WIDTH,  16'hFFFF);
        script_reg (CFG_IMAGE_HEIGHT, 16'hFFFF);
        script_byte(8'hFF, 1'b1);
        script_byte(8'hFF, 1'b0);
        script_byte(8'hFF, 1'b0);
        script_byte(8'hFF, 1'b0);
        script_run (8'h00, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'd128, 1'b0, 1'b0);
        // raw single pixel; pixel size drops to 3 after two bytes are in
        script_byte(8'h00, 1'b0);
        script_byte(8'h11, 1'b0);
        script_byte(8'h22, 1'b0);
        script_reg (CFG_PIXEL_BYTES,  DIM_W'(PIXEL_BYTES_RESET));
        script_byte(8'h33, 1'b0);
        // image shrunk below the 129 pixels already out: treated as done
        script_reg (CFG_IMAGE_WIDTH,  16'd100);
        script_reg (CFG_IMAGE_HEIGHT, 16'd1);
        script_byte(8'h55, 1'b0);
        // odd pixel size (0 -> 3 bytes); raw 3-pixel packet into a 2-pixel image
        script_reg (CFG_PIXEL_BYTES,  16'd0);
        script_reg (CFG_IMAGE_WIDTH,  16'd2);
        script_byte(8'h02, 1'b1);
        script_byte(8'h01, 1'b0);
        script_byte(8'h80, 1'b0);
        script_run (8'hFE, 1'b0, 8'hFE, 8'h80, 8'h01, 8'd1, 1'b0, 1'b0);
        script_byte(8'h7F, 1'b0);
        script_byte(8'h00, 1'b0);
        script_run (8'hC3, 1'b0, 8'hC3, 8'h00, 8'h7F, 8'd1, 1'b1, 1'b1);
        // zero-width image: even a restart header is dropped
        script_reg (CFG_IMAGE_WIDTH,  16'd0);
        script_byte(8'h80, 1'b1);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                wait_idle();
                write_reg(script[i].idx, script[i].value);
            end else begin
                send_byte(script[i].value[BYTE_W-1:0], script[i].fs,
                          script[i].typed, script[i].want);
            end
        end

        // Random part: each setup is a fresh config followed by an image (mostly
        // well-formed packets, random content) or a burst of noise.
        while (bytes_used < ITEMS_TARGET) begin
            phases++;
            tail = (bytes_used > ITEMS_TARGET - TAIL_ITEMS);
            wait_idle();
            if (tail) begin
                tx_idle_odds = 0;
                rx_idle_odds = 0;
            end else begin
                tx_idle_odds = 15 * $urandom_range(0, 2);
                rx_idle_odds = 15 * $urandom_range(0, 2);
            end

            shape = $urandom_range(0, 19);
            if ($urandom_range(0, 7) == 0)
                pb_pick = $urandom_range(0, 7);
            else
                pb_pick = $urandom_range(0, 1) ? 32'(PIXEL_BYTES_WIDE)
                                               : 32'(PIXEL_BYTES_RESET);
            if (shape == 0) begin
                // huge image: packets are sent only until 40 pixels are covered
                w = $urandom_range(0, 1) ? 16'hFFFF : DIM_W'($urandom_range(1, 65535));
                h = $urandom_range(0, 1) ? 16'hFFFF : DIM_W'($urandom_range(1, 65535));
            end else if (shape == 1) begin
                w = $urandom_range(0, 1) ? 16'd0 : DIM_W'($urandom_range(1, 8));
                h = (w == 0) ? DIM_W'($urandom_range(0, 6)) : 16'd0;
            end else begin
                w = DIM_W'($urandom_range(1, 8));
                h = DIM_W'($urandom_range(1, 6));
            end
            write_reg(CFG_PIXEL_BYTES,  DIM_W'(pb_pick));
            write_reg(CFG_IMAGE_WIDTH,  w);
            write_reg(CFG_IMAGE_HEIGHT, h);

            if (!tail && phases % 10 == 3) begin
                // receiver sits still while bytes keep coming
                rx_long_hold_req = 1'b1;
                tx_idle_odds     = 0;
            end

            if (shape == 1 || $urandom_range(0, 11) == 0) begin
                repeat ($urandom_range(8, 30))
                    send_byte(BYTE_W'($urandom), $urandom_range(0, 5) == 0);
            end else begin
                cap     = (shape == 0) ? 40 : 32'(w) * 32'(h);
                made    = 0;
                restart = 1'b1;
                while (made < cap) begin
                    rep = 1'($urandom_range(0, 1));
                    cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 7);
                    send_byte({rep, COUNT_W'(cnt)}, restart);
                    restart = 1'b0;
                    for (p = 0; p < (rep ? 1 : cnt + 1) && made < cap; p++) begin
                        if ($urandom_range(0, 249) == 0) begin
                            // broken packet: cut short, possibly mid-pixel, restart the frame
                            send_pixel($urandom_range(0, px_bytes() - 1));
                            restart = 1'b1;
                            made    = 0;
                            break;
                        end
                        send_pixel(px_bytes());
                        made += rep ? cnt + 1 : 1;
                    end
                end
                // stray bytes past the end of the image
                repeat ($urandom_range(0, 2)) send_byte(BYTE_W'($urandom), 1'b0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d decoded bytes: %0d directed rows, then %0d random setups",
                 bytes_used, script.size(), phases);
        $display("%0d runs checked, %0d image ends, %0d clipped runs, %0d mismatches",
                 runs_checked, image_ends, clipped_runs, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: tga_rle_pixel_decoder.f
hw/rtl/trd_pkg.sv
hw/rtl/trd_queue.sv
hw/rtl/trd_front.sv
hw/rtl/trd_back.sv
hw/rtl/tga_rle_pixel_decoder.sv
verif/tga_rle_pixel_decoder_test.sv
